// ===== rtl/spring_force_vector_assert.svh =====
// Assertion macros for the spring force pipeline.
// Included by the top level; needs a clock named i_clk and a reset named i_rst_n.
`ifndef SPRING_FORCE_VECTOR_ASSERT_SVH
`define SPRING_FORCE_VECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SFV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SFV_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SFV_ASSERT(label, prop, msg)
`define SFV_ASSERT_NR(label, prop, msg)
`endif
`endif

// ===== rtl/sfv_pkg.sv =====
// Shared constants for the spring force pipeline.
// No dependencies.
`timescale 1ns / 1ps
package sfv_pkg;
    localparam int          SFV_FRAC_BITS   = 16;
    localparam int          SFV_ADDR_W      = 3;
    localparam logic        REG_SPRING_K    = 1'b0;
    localparam logic        REG_REST_LEN    = 1'b1;
    localparam logic [31:0] SPRING_K_RESET  = 32'h0001_0000;
    localparam logic [30:0] REST_LEN_RESET  = 31'h0;
    localparam logic [31:0] FORCE_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] FORCE_MIN       = 32'h8000_0000;
endpackage

// ===== rtl/spring_force_vector.sv =====
// Top level of the pipelined 2-D spring force unit with its APB register port.
// Depends on sfv_pkg and spring_force_vector_assert.svh.
`timescale 1ns / 1ps
// The block accepts one item per clock while the output is not stalled. Its pipeline
// holds the 34 stages of the bit-per-stage square root and the FRAC_BITS + 1 stages
// of the two parallel dividers. When the output is stalled the whole pipeline holds,
// and the input stall follows.
`include "spring_force_vector_assert.svh"
module spring_force_vector import sfv_pkg::*; #(
    parameter int FRAC_BITS = SFV_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [SFV_ADDR_W-1:0]  paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic signed [31:0]     i_particle_x,
    input  logic signed [31:0]     i_particle_y,
    input  logic signed [31:0]     i_anchor_x,
    input  logic signed [31:0]     i_anchor_y,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [31:0]     o_force_x,
    output logic signed [31:0]     o_force_y,
    output logic                   o_saturated
);
    localparam int NSQ = 34;
    localparam int NDV = FRAC_BITS + 1;
    localparam int DW  = 35 + FRAC_BITS;
    localparam int UW  = FRAC_BITS + 1;
    localparam int PW  = 65 + FRAC_BITS;
    localparam int MW  = PW - 2 * FRAC_BITS;

    typedef struct packed {
        logic [65:0] rem;
        logic [33:0] root;
        logic [32:0] ax;
        logic [32:0] ay;
        logic        nx;
        logic        ny;
    } t_sq;

    typedef struct packed {
        logic [33:0]   len;
        logic [DW-1:0] rx;
        logic [DW-1:0] ry;
        logic [UW-1:0] qx;
        logic [UW-1:0] qy;
        logic          nx;
        logic          ny;
    } t_dv;

    logic [31:0] r_k;
    logic [30:0] r_rest;
    logic        w_en;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REST_LEN) ? {1'b0, r_rest} : r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= SPRING_K_RESET;
            r_rest <= REST_LEN_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_SPRING_K: r_k    <= pwdata;
                REG_REST_LEN: r_rest <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // Offset and magnitudes.
    logic signed [32:0] w_dx, w_dy;
    logic [32:0] r0_ax, r0_ay;
    logic        r0_nx, r0_ny, r0_v;
    assign w_dx = 33'(i_particle_x) - 33'(i_anchor_x);
    assign w_dy = 33'(i_particle_y) - 33'(i_anchor_y);

    // Squares.
    logic [65:0] r1_sx, r1_sy;
    logic [32:0] r1_ax, r1_ay;
    logic        r1_nx, r1_ny, r1_v;

    t_sq  r_sq   [NSQ+1];
    logic r_sq_v [NSQ+1];
    t_sq  n_sq   [NSQ+1];

    t_dv  r_dv   [NDV+1];
    logic r_dv_v [NDV+1];
    t_dv  n_dv   [NDV+1];

    always_comb begin
        logic [67:0] trial;
        int          b;
        n_sq[0].rem  = r1_sx + r1_sy;
        n_sq[0].root = '0;
        n_sq[0].ax   = r1_ax;
        n_sq[0].ay   = r1_ay;
        n_sq[0].nx   = r1_nx;
        n_sq[0].ny   = r1_ny;
        for (int i = 0; i < NSQ; i++) begin
            b = NSQ - 1 - i;
            trial = (68'(r_sq[i].root) << (b + 1)) + (68'(1) << (2 * b));
            n_sq[i+1] = r_sq[i];
            if (68'(r_sq[i].rem) >= trial) begin
                n_sq[i+1].rem  = 66'(68'(r_sq[i].rem) - trial);
                n_sq[i+1].root = r_sq[i].root | (34'(1) << b);
            end
        end
    end

    always_comb begin
        logic [DW-1:0] dsh;
        int            j;
        n_dv[0].len = r_sq[NSQ].root;
        n_dv[0].rx  = DW'(r_sq[NSQ].ax) << FRAC_BITS;
        n_dv[0].ry  = DW'(r_sq[NSQ].ay) << FRAC_BITS;
        n_dv[0].qx  = '0;
        n_dv[0].qy  = '0;
        n_dv[0].nx  = r_sq[NSQ].nx;
        n_dv[0].ny  = r_sq[NSQ].ny;
        for (int i = 0; i < NDV; i++) begin
            j = NDV - 1 - i;
            dsh = DW'(r_dv[i].len) << j;
            n_dv[i+1] = r_dv[i];
            if (r_dv[i].rx >= dsh) begin
                n_dv[i+1].rx = r_dv[i].rx - dsh;
                n_dv[i+1].qx = r_dv[i].qx | (UW'(1) << j);
            end
            if (r_dv[i].ry >= dsh) begin
                n_dv[i+1].ry = r_dv[i].ry - dsh;
                n_dv[i+1].qy = r_dv[i].qy | (UW'(1) << j);
            end
        end
    end

    // Stretch times stiffness, in two partial products.
    logic signed [34:0] w_e;
    logic [33:0]   w_ea;
    logic [31:0]   w_ka;
    logic [48:0]   r1p_lo, r1p_hi;
    logic [UW-1:0] r1p_ux, r1p_uy;
    logic          r1p_nx, r1p_ny, r1p_zero, r1p_v;
    logic          w_base_neg;
    assign w_e  = 35'(r_dv[NDV].len) - 35'(r_rest);
    assign w_ea = w_e[34] ? 34'(-w_e) : w_e[33:0];
    assign w_ka = r_k[31] ? 32'(-r_k) : r_k;
    assign w_base_neg = !(r_k[31] != w_e[34]);

    logic [63:0]   r2_m;
    logic [UW-1:0] r2_ux, r2_uy;
    logic          r2_nx, r2_ny, r2_zero, r2_v;

    logic [32+UW-1:0] r3_xl, r3_xh, r3_yl, r3_yh;
    logic             r3_nx, r3_ny, r3_zero, r3_v;

    logic [PW-1:0] w_px, w_py;
    logic [MW-1:0] w_mx, w_my;
    logic [32:0]   w_fx, w_fy;
    assign w_px = PW'(r3_xl) + (PW'(r3_xh) << 32);
    assign w_py = PW'(r3_yl) + (PW'(r3_yh) << 32);
    assign w_mx = w_px[PW-1:2*FRAC_BITS];
    assign w_my = w_py[PW-1:2*FRAC_BITS];

    function automatic logic [32:0] f_sat(input logic [MW-1:0] mag, input logic neg);
        logic [MW-1:0] lim;
        logic [31:0]   v;
        logic          s;
        lim = neg ? MW'(FORCE_MIN) : MW'(FORCE_MAX);
        s   = mag > lim;
        v   = s ? lim[31:0] : mag[31:0];
        return {s, neg ? 32'(-v) : v};
    endfunction

    assign w_fx = f_sat(w_mx, r3_nx);
    assign w_fy = f_sat(w_my, r3_ny);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0; r1_v <= 1'b0; r1p_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0;
            o_out_valid <= 1'b0;
            for (int i = 0; i <= NSQ; i++) r_sq_v[i] <= 1'b0;
            for (int i = 0; i <= NDV; i++) r_dv_v[i] <= 1'b0;
        end else if (w_en) begin
            r0_v <= i_in_valid;
            r1_v <= r0_v;
            r_sq_v[0] <= r1_v;
            for (int i = 0; i < NSQ; i++) r_sq_v[i+1] <= r_sq_v[i];
            r_dv_v[0] <= r_sq_v[NSQ];
            for (int i = 0; i < NDV; i++) r_dv_v[i+1] <= r_dv_v[i];
            r1p_v <= r_dv_v[NDV];
            r2_v  <= r1p_v;
            r3_v  <= r2_v;
            o_out_valid <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_ax <= w_dx[32] ? 33'(-w_dx) : w_dx;
            r0_ay <= w_dy[32] ? 33'(-w_dy) : w_dy;
            r0_nx <= w_dx[32];
            r0_ny <= w_dy[32];
            r1_sx <= 66'(r0_ax) * 66'(r0_ax);
            r1_sy <= 66'(r0_ay) * 66'(r0_ay);
            r1_ax <= r0_ax; r1_ay <= r0_ay; r1_nx <= r0_nx; r1_ny <= r0_ny;
            for (int i = 0; i <= NSQ; i++) r_sq[i] <= n_sq[i];
            for (int i = 0; i <= NDV; i++) r_dv[i] <= n_dv[i];
            r1p_lo   <= 49'(w_ka) * 49'(w_ea[16:0]);
            r1p_hi   <= 49'(w_ka) * 49'(w_ea[33:17]);
            r1p_ux   <= r_dv[NDV].qx;
            r1p_uy   <= r_dv[NDV].qy;
            r1p_nx   <= w_base_neg != r_dv[NDV].nx;
            r1p_ny   <= w_base_neg != r_dv[NDV].ny;
            r1p_zero <= r_dv[NDV].len == '0;
            r2_m    <= 64'(66'(r1p_lo) + (66'(r1p_hi) << 17));
            r2_ux   <= r1p_ux; r2_uy <= r1p_uy;
            r2_nx   <= r1p_nx; r2_ny <= r1p_ny; r2_zero <= r1p_zero;
            r3_xl   <= (32+UW)'(r2_m[31:0])  * (32+UW)'(r2_ux);
            r3_xh   <= (32+UW)'(r2_m[63:32]) * (32+UW)'(r2_ux);
            r3_yl   <= (32+UW)'(r2_m[31:0])  * (32+UW)'(r2_uy);
            r3_yh   <= (32+UW)'(r2_m[63:32]) * (32+UW)'(r2_uy);
            r3_nx   <= r2_nx; r3_ny <= r2_ny; r3_zero <= r2_zero;
            o_force_x   <= r3_zero ? 32'sd0 : w_fx[31:0];
            o_force_y   <= r3_zero ? 32'sd0 : w_fy[31:0];
            o_saturated <= !r3_zero && (w_fx[32] || w_fy[32]);
        end
    end

    `SFV_ASSERT(a_sat_extreme, o_out_valid && o_saturated |-> (o_force_x == FORCE_MAX || o_force_x == FORCE_MIN || o_force_y == FORCE_MAX || o_force_y == FORCE_MIN), "saturated result holds no clamped component")
    `SFV_ASSERT(a_hold_on_stall, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_force_x) && $stable(o_force_y), "result changed while stalled")
    `SFV_ASSERT_NR(a_reset_empty, !i_rst_n |=> !o_out_valid && !r_sq_v[0], "pipeline not empty after reset")
endmodule

// ===== tb/spring_force_vector_test.sv =====
// Self-checking testbench for the 2-D spring force pipeline spring_force_vector.
// Drives items through the valid/stall channels and the APB register port, and
// compares each force against a built-in bit-exact predictor. Depends on sfv_pkg.
`timescale 1ns / 1ps
module spring_force_vector_test;
    import sfv_pkg::*;

    localparam int FB = SFV_FRAC_BITS;
    localparam int LATENCY = 43 + FB;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic               sat;
    } t_force;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [SFV_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [31:0] i_particle_x = '0, i_particle_y = '0, i_anchor_x = '0, i_anchor_y = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [31:0] o_force_x, o_force_y;
    logic o_saturated;

    spring_force_vector DUT (.*);

    always #5 i_clk = ~i_clk;

    logic signed [31:0] stiffness = SPRING_K_RESET;
    logic [30:0] rest_len = REST_LEN_RESET;
    t_force expected_forces[$];
    int mismatches = 0;
    int forces_seen = 0;
    int items_sent = 0;
    longint cycles = 0;
    bit hold_output = 1'b0;
    int hold_cycles = 0;
    int out_wait = 0;
    bit out_idle_enable = 1'b1;

    function automatic logic [67:0] root_of(logic [67:0] s);
        logic [67:0] r, t;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            t = r | (68'd1 << b);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp_force(logic [127:0] mag, logic neg, ref logic sat);
        logic [127:0] q, lim;
        q = mag >> (2 * FB);
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) begin
            sat = 1'b1;
            q = lim;
        end
        return neg ? 32'(-q[32:0]) : q[31:0];
    endfunction

    function automatic t_force spring_force(logic signed [31:0] px, logic signed [31:0] py,
                                            logic signed [31:0] ax, logic signed [31:0] ay);
        logic signed [33:0] dx, dy, e;
        logic [33:0] mx, my, len;
        logic [63:0] ux, uy;
        logic [127:0] m;
        logic [31:0] kmag;
        logic base_neg, sat;
        t_force f;
        dx = px - ax;
        dy = py - ay;
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        len = 34'(root_of(68'(mx) * 68'(mx) + 68'(my) * 68'(my)));
        f = '0;
        if (len == 0) return f;
        ux = (64'(mx) << FB) / 64'(len);
        uy = (64'(my) << FB) / 64'(len);
        e = 34'($signed({1'b0, len}) - $signed({3'b0, rest_len}));
        kmag = stiffness < 0 ? -stiffness : stiffness;
        m = 128'(kmag) * 128'(e < 0 ? -e : e);
        base_neg = !((stiffness < 0) != (e < 0));
        sat = 1'b0;
        f.fx = clamp_force(m * 128'(ux), base_neg != (dx < 0), sat);
        f.fy = clamp_force(m * 128'(uy), base_neg != (dy < 0), sat);
        f.sat = sat;
        return f;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("** spring_force_vector: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_force want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            forces_seen++;
            if (expected_forces.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected force item at cycle %0d.", cycles);
            end else begin
                want = expected_forces.pop_front();
                if (o_force_x !== want.fx || o_force_y !== want.fy || o_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %h %h %b, got %h %h %b", want.fx,
                                 want.fy, want.sat, o_force_x, o_force_y, o_saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        int draw;
        draw = out_idle_enable ? int'($urandom_range(0, 7)) : 0;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else if (hold_output) begin
            hold_output <= 1'b0;
            hold_cycles <= 300;
            i_out_stall <= 1'b1;
        end else if (out_wait > 0) begin
            out_wait <= out_wait - 1;
            i_out_stall <= 1'b1;
        end else if (o_out_valid && !i_out_stall && draw > 0) begin
            out_wait <= draw - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_item(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] ax, logic signed [31:0] ay, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_particle_x <= px;
        i_particle_y <= py;
        i_anchor_x <= ax;
        i_anchor_y <= ay;
        expected_forces = {expected_forces, spring_force(px, py, ax, ay)};
        items_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_register(logic idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= SFV_ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_SPRING_K) stiffness = value;
        else rest_len = value[30:0];
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_forces.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        unique case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    task automatic test_directed();
        send_item(0, 0, 0, 0, 0);
        send_item(32'h1234_5678, -5, 32'h1234_5678, -5, 0);
        send_item(32'h0001_0000, 0, 0, 0, 0);
        send_item(0, 32'hFFFF_0000, 0, 0, 0);
        send_item(1, 0, 0, 0, 0);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_item(32'h0003_0000, 32'h0004_0000, 0, 0, 0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1);
        drain();
        write_register(REG_REST_LEN, 32'h0005_0000);
        send_item(32'h0003_0000, 32'h0004_0000, 0, 0, 0);
        send_item(32'h0001_0000, 0, 0, 0, 0);
        send_item(32'h0100_0000, 32'h0200_0000, 0, 0, 0);
        drain();
        write_register(REG_SPRING_K, 32'h8000_0000);
        write_register(REG_REST_LEN, 32'h7FFF_FFFF);
        send_item(32'h0003_0000, 32'h0004_0000, 0, 0, 0);
        send_item(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0);
        send_item(2, 3, 0, 0, 1);
        drain();
        write_register(REG_SPRING_K, 32'h7FFF_FFFF);
        write_register(REG_REST_LEN, 0);
        send_item(32'h0001_0000, 32'h0001_0000, 0, 0, 0);
        send_item(3, 0, 0, 0, 0);
        drain();
        write_register(REG_SPRING_K, 0);
        send_item(32'h0100_0000, 32'h0000_1000, 0, 0, 0);
        drain();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++) begin
            write_register(REG_SPRING_K, phase == 0 ? 32'h0001_0000 :
                           phase == 1 ? 32'hFFFF_8000 : $urandom_range(0, 1) ?
                           32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) : $urandom);
            write_register(REG_REST_LEN, phase == 0 ? 0 : $urandom_range(0, 1) ?
                           $urandom_range(0, 1 << 22) : $urandom);
            out_idle_enable = (phase != 3);
            for (int n = 0; n < 100; n++)
                send_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), phase != 3);
            drain();
        end
    endtask

    task automatic test_backpressure();
        hold_output = 1'b1;
        for (int n = 0; n < 90; n++)
            send_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 0);
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_settings();
        test_backpressure();
        $display("Sent %0d items over several stiffness and rest length settings,", items_sent);
        $display("checked %0d force items, including a long output hold.", forces_seen);
        if (mismatches == 0 && expected_forces.size() == 0) begin
            $display("** spring_force_vector: PASSED **");
        end else begin
            $display("%0d mismatches, %0d items missing.", mismatches, expected_forces.size());
            $display("** spring_force_vector: FAILED **");
        end
        $finish;
    end
endmodule

// ===== spring_force_vector.f =====
+incdir+rtl
rtl/sfv_pkg.sv
rtl/spring_force_vector.sv
tb/spring_force_vector_test.sv
